[design/bssg_pkg.sv]
// Shared types, register indexes and reset values for the bar-synced step gate sequencer.
package bssg_pkg;

    // Configuration register file.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BAR_LENGTH   = 3'd0,
        REG_RESYNC_BARS  = 3'd1,
        REG_STEP_LENGTH  = 3'd2,
        REG_GATE_LENGTH  = 3'd3,
        REG_STEP_COUNT   = 3'd4,
        REG_PATTERN_BITS = 3'd5
    } cfg_reg_t;

    localparam logic [23:0] RST_BAR_LENGTH   = 24'd96000;
    localparam logic [5:0]  RST_RESYNC_BARS  = 6'd1;
    localparam logic [23:0] RST_STEP_LENGTH  = 24'd6000;
    localparam logic [23:0] RST_GATE_LENGTH  = 24'd3000;
    localparam logic [5:0]  RST_STEP_COUNT   = 6'd16;
    localparam logic [31:0] RST_PATTERN_BITS = 32'd0;

    // Most bars between pattern restarts.
    localparam logic [5:0] MAX_RESYNC_BARS = 6'd32;

    // Width that holds any step number and any step count up to 64.
    localparam int STEP_EXT_W = 7;

    typedef struct packed {
        logic [23:0] bar_length;
        logic [5:0]  resync_bars;
        logic [23:0] step_length;
        logic [23:0] gate_length;
        logic [5:0]  step_count;
        logic [31:0] pattern_bits;
    } cfg_t;

    typedef struct packed {
        logic       gate_open;
        logic [4:0] step_index;
        logic       step_start;
    } result_t;

endpackage

[design/bar_synced_step_gate_sequencer_top.sv]
// Top level of the bar-synced step gate sequencer: handshake registers around the core.
// An accepted input word passes through the input register and then the result register.
// Throughput: one word per cycle; the input register and the result register
// form a two-stage pipe that stalls only while the result register is held.
// Reset (aresetn low, synchronous) empties both stages, loads the register
// defaults and clears the counters, with the gate counter marked idle.
module bar_synced_step_gate_sequencer_top #(
    parameter int MAX_STEPS  = 32,
    parameter int COUNT_BITS = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_playing,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_gate_open,
    output logic [4:0]                          m_step_index,
    output logic                                m_step_start,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bssg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bssg_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bssg_pkg::*;

    cfg_t    cfg;
    result_t res;
    result_t res_reg;
    logic    in_valid_reg;
    logic    in_playing_reg;
    logic    out_valid_reg;
    logic    advance;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    bssg_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The held word moves to the result register when that register is free.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    bssg_core #(
        .MAX_STEPS  (MAX_STEPS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick_en (advance),
        .playing (in_playing_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_playing_reg <= s_playing;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_gate_open  = res_reg.gate_open;
    assign m_step_index = res_reg.step_index;
    assign m_step_start = res_reg.step_start;

endmodule

[design/bssg_cfg_regs.sv]
// Configuration register file of the bar-synced step gate sequencer.
module bssg_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [bssg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bssg_pkg::CFG_DATA_W-1:0]     cfg_data,
    output bssg_pkg::cfg_t                      cfg
);
    import bssg_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write word; unknown indexes leave the registers alone.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_BAR_LENGTH:   cfg_next.bar_length   = cfg_data[23:0];
                REG_RESYNC_BARS:  cfg_next.resync_bars  = cfg_data[5:0];
                REG_STEP_LENGTH:  cfg_next.step_length  = cfg_data[23:0];
                REG_GATE_LENGTH:  cfg_next.gate_length  = cfg_data[23:0];
                REG_STEP_COUNT:   cfg_next.step_count   = cfg_data[5:0];
                REG_PATTERN_BITS: cfg_next.pattern_bits = cfg_data[31:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bar_length   <= RST_BAR_LENGTH;
            cfg_reg.resync_bars  <= RST_RESYNC_BARS;
            cfg_reg.step_length  <= RST_STEP_LENGTH;
            cfg_reg.gate_length  <= RST_GATE_LENGTH;
            cfg_reg.step_count   <= RST_STEP_COUNT;
            cfg_reg.pattern_bits <= RST_PATTERN_BITS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/bssg_core.sv]
// Sequencer state registers and the per-tick next-state logic.
module bssg_core #(
    parameter int MAX_STEPS  = 32,
    parameter int COUNT_BITS = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                tick_en,
    input  logic                playing,
    input  bssg_pkg::cfg_t      cfg,
    output bssg_pkg::result_t   res
);
    import bssg_pkg::*;

    localparam int CW = COUNT_BITS;
    localparam int EW = (COUNT_BITS > 24) ? COUNT_BITS : 24;
    localparam int SW = (MAX_STEPS > 2) ? $clog2(MAX_STEPS) : 1;
    localparam int XW = STEP_EXT_W;

    logic [CW-1:0] bar_pos_reg, bar_pos_next;
    logic [4:0]    bar_num_reg, bar_num_next;
    logic [CW-1:0] step_pos_reg, step_pos_next;
    logic [SW-1:0] step_num_reg, step_num_next;
    logic [CW-1:0] gate_count_reg, gate_count_next;
    logic          gate_idle_reg, gate_idle_next;
    logic          gate_flag_reg, gate_flag_next;
    logic          prev_playing_reg;

    logic [23:0]   blen, slen, glen;
    logic [EW-1:0] blen_m1_ext, slen_m1_ext;
    logic [5:0]    nbars;
    logic [XW-1:0] nsteps_raw, nsteps;
    logic          play_edge;
    logic [CW-1:0] bar_pos_a, bar_inc, step_pos_a, step_inc, gate_inc;
    logic [4:0]    bar_num_a;
    logic [5:0]    bar_num_p1;
    logic [4:0]    bar_num_b;
    logic          resync;
    logic [SW-1:0] step_num_a;
    logic [XW-1:0] step_num_p1, step_num_ext;
    logic          started;
    logic          pat_bit;

    // Effective moduli: zero acts as one, and the counts are clamped.
    always_comb begin
        blen = (cfg.bar_length  == 24'd0) ? 24'd1 : cfg.bar_length;
        slen = (cfg.step_length == 24'd0) ? 24'd1 : cfg.step_length;
        glen = (cfg.gate_length == 24'd0) ? 24'd1 : cfg.gate_length;
        blen_m1_ext = EW'(blen - 24'd1);
        slen_m1_ext = EW'(slen - 24'd1);
        if (cfg.resync_bars == 6'd0) begin
            nbars = 6'd1;
        end else if (cfg.resync_bars > MAX_RESYNC_BARS) begin
            nbars = MAX_RESYNC_BARS;
        end else begin
            nbars = cfg.resync_bars;
        end
        nsteps_raw = (cfg.step_count == 6'd0) ? XW'(1) : XW'(cfg.step_count);
        nsteps = (nsteps_raw > XW'(MAX_STEPS)) ? XW'(MAX_STEPS) : nsteps_raw;
    end

    // Bar counters, with the preset on a stopped-to-playing edge.
    always_comb begin
        play_edge  = playing && !prev_playing_reg;
        bar_pos_a  = play_edge ? blen_m1_ext[CW-1:0] : bar_pos_reg;
        bar_num_a  = play_edge ? 5'(nbars - 6'd1) : bar_num_reg;
        bar_inc    = bar_pos_a + CW'(1);
        bar_pos_next = (EW'(bar_inc) >= EW'(blen)) ? '0 : bar_inc;
        bar_num_p1 = {1'b0, bar_num_a} + 6'd1;
        bar_num_b  = (bar_num_p1 >= nbars) ? 5'd0 : bar_num_p1[4:0];
        bar_num_next = (bar_pos_next == '0) ? bar_num_b : bar_num_a;
        resync     = (bar_pos_next == '0) && (bar_num_b == 5'd0);
    end

    // Step counters, gate close and then gate open on step start.
    always_comb begin
        step_pos_a = resync ? slen_m1_ext[CW-1:0] : step_pos_reg;
        step_num_a = resync ? SW'(nsteps - XW'(1)) : step_num_reg;
        step_inc   = step_pos_a + CW'(1);
        step_pos_next = (EW'(step_inc) >= EW'(slen)) ? '0 : step_inc;
        started    = (step_pos_next == '0);

        gate_count_next = gate_count_reg;
        gate_idle_next  = gate_idle_reg;
        gate_flag_next  = gate_flag_reg;
        gate_inc = gate_count_reg + CW'(1);
        if (!gate_idle_reg) begin
            gate_count_next = (EW'(gate_inc) >= EW'(glen)) ? '0 : gate_inc;
            if (gate_count_next == '0) begin
                gate_idle_next = 1'b1;
                gate_flag_next = 1'b0;
            end
        end

        step_num_p1   = XW'(step_num_a) + XW'(1);
        step_num_next = step_num_a;
        if (started) begin
            step_num_next = (step_num_p1 >= nsteps) ? '0 : step_num_p1[SW-1:0];
        end
        step_num_ext = XW'(step_num_next);
        pat_bit = (step_num_ext < XW'(32)) && cfg.pattern_bits[step_num_ext[4:0]];
        if (started && pat_bit) begin
            gate_count_next = CW'(1);
            gate_idle_next  = 1'b0;
            gate_flag_next  = 1'b1;
        end

        res.gate_open  = gate_flag_next;
        res.step_index = step_num_ext[4:0];
        res.step_start = started;
    end

    // State update, one tick per accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bar_pos_reg      <= '0;
            bar_num_reg      <= '0;
            step_pos_reg     <= '0;
            step_num_reg     <= '0;
            gate_count_reg   <= '0;
            gate_idle_reg    <= 1'b1;
            gate_flag_reg    <= 1'b0;
            prev_playing_reg <= 1'b0;
        end else if (tick_en) begin
            bar_pos_reg      <= bar_pos_next;
            bar_num_reg      <= bar_num_next;
            step_pos_reg     <= step_pos_next;
            step_num_reg     <= step_num_next;
            gate_count_reg   <= gate_count_next;
            gate_idle_reg    <= gate_idle_next;
            gate_flag_reg    <= gate_flag_next;
            prev_playing_reg <= playing;
        end
    end

endmodule

[design/bssg_checker.sv]
// Port-level assertions for the sequencer top level and the bind that attaches them.
module bssg_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_gate_open,
    input logic [4:0] m_step_index,
    input logic       m_step_start
);
    logic last_gate_reg;

    // Gate state of the last delivered word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_gate_reg <= 1'b0;
        end else if (m_valid && m_ready) begin
            last_gate_reg <= m_gate_open;
        end
    end

    // A stalled result word holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_gate_open)
            && $stable(m_step_index) && $stable(m_step_start))
        else $error("result word changed while stalled");

    // Reset empties the result register.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // After an accepted word the result output is valid, with that word or an older one still held.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> ##2 m_valid)
        else $error("accepted word produced no result in time");

    // The gate opens only on a step start.
    a_gate_open: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_gate_open && !last_gate_reg |-> m_step_start)
        else $error("gate opened without a step start");

endmodule

bind bar_synced_step_gate_sequencer_top bssg_checker u_bssg_checker (.*);

[test/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the bar-synced step gate sequencer: directed table, then random phases.
module tb_top;
    import bssg_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 6;
    localparam int COUNT_W      = 24;
    localparam int MAX_STEPS    = 32;
    localparam int NUM_PHASES   = 13;
    localparam int IDLE_LIMIT   = 200;
    localparam int TAIL_CYCLES  = 8;

    // Index that maps to no register; a write to it must change nothing.
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;

    typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  data;
        logic                   playing;
        bit                     typed;
        result_t                want;
    } row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    logic                   s_playing = 1'b0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic                   m_gate_open;
    logic [4:0]             m_step_index;
    logic                   m_step_start;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Register copy kept by the predictor.
    logic [23:0] bar_len_q, step_len_q, gate_len_q;
    logic [5:0]  resync_q, steps_q;
    logic [31:0] pattern_q;

    // Counter state kept by the predictor.
    logic [23:0] bar_pos, step_pos, gate_cnt;
    logic [4:0]  bar_num, step_num;
    logic        gate_idle, gate_on, was_playing;

    result_t step_words_due[$];
    result_t head_word;
    int      mismatch_count = 0;
    int      words_seen     = 0;
    int      quiet_cycles   = 0;
    bit      tx_gaps        = 1'b1;
    bit      rx_stalls      = 1'b1;

    bar_synced_step_gate_sequencer_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_playing    (s_playing),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_gate_open  (m_gate_open),
        .m_step_index (m_step_index),
        .m_step_start (m_step_start),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // Report one mismatch on a line of its own and count it.
    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    // Load register defaults and clear the counters, as reset does.
    task automatic reset_sequencer_copy();
        bar_len_q   = RST_BAR_LENGTH;
        resync_q    = RST_RESYNC_BARS;
        step_len_q  = RST_STEP_LENGTH;
        gate_len_q  = RST_GATE_LENGTH;
        steps_q     = RST_STEP_COUNT;
        pattern_q   = RST_PATTERN_BITS;
        bar_pos     = '0;
        bar_num     = '0;
        step_pos    = '0;
        step_num    = '0;
        gate_cnt    = '0;
        gate_idle   = 1'b1;
        gate_on     = 1'b0;
        was_playing = 1'b0;
    endtask

    // Mirror a register write; unmapped indexes are ignored.
    task automatic store_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        case (idx)
            REG_BAR_LENGTH:   bar_len_q  = data[23:0];
            REG_RESYNC_BARS:  resync_q   = data[5:0];
            REG_STEP_LENGTH:  step_len_q = data[23:0];
            REG_GATE_LENGTH:  gate_len_q = data[23:0];
            REG_STEP_COUNT:   steps_q    = data[5:0];
            REG_PATTERN_BITS: pattern_q  = data;
            default: ;
        endcase
    endtask

    // Increment, then clear once the value reaches the modulus.
    function automatic logic [23:0] count_wrap(input logic [23:0] v, input int unsigned modulus);
        logic [23:0] n;
        n = v + 24'd1;
        return (n >= modulus) ? 24'd0 : n;
    endfunction

    // Advance the sequencer copy by one sample tick and return the word it should emit.
    function automatic result_t advance_sequencer(input logic playing);
        int unsigned blen, slen, glen, nbars, nsteps;
        logic        started;
        result_t     word;
        blen    = (bar_len_q == 0) ? 1 : bar_len_q;
        slen    = (step_len_q == 0) ? 1 : step_len_q;
        glen    = (gate_len_q == 0) ? 1 : gate_len_q;
        nbars   = (resync_q == 0) ? 1 : ((resync_q > 32) ? 32 : resync_q);
        nsteps  = (steps_q == 0) ? 1 : ((steps_q > MAX_STEPS) ? MAX_STEPS : steps_q);
        started = 1'b0;

        // A start of play presets the bar counters so the resync lands on this tick.
        if (!was_playing && playing) begin
            bar_num = 5'(nbars - 1);
            bar_pos = COUNT_W'(blen - 1);
        end
        was_playing = playing;

        // Bar counters; a full resync presets the step counters.
        bar_pos = count_wrap(bar_pos, blen);
        if (bar_pos == 0) begin
            bar_num = (int'(bar_num) + 1 >= nbars) ? 5'd0 : bar_num + 5'd1;
            if (bar_num == 0) begin
                step_num = 5'(nsteps - 1);
                step_pos = COUNT_W'(slen - 1);
            end
        end

        step_pos = count_wrap(step_pos, slen);

        // The gate closes before a step start can reopen it.
        if (!gate_idle) begin
            gate_cnt = count_wrap(gate_cnt, glen);
            if (gate_cnt == 0) begin
                gate_idle = 1'b1;
                gate_on   = 1'b0;
            end
        end

        if (step_pos == 0) begin
            started  = 1'b1;
            step_num = (int'(step_num) + 1 >= nsteps) ? 5'd0 : step_num + 5'd1;
            if (pattern_q[step_num]) begin
                gate_cnt  = 24'd1;
                gate_idle = 1'b0;
                gate_on   = 1'b1;
            end
        end

        word.gate_open  = gate_on;
        word.step_index = step_num;
        word.step_start = started;
        return word;
    endfunction

    // Offer one input word after a random gap and queue its expected result.
    task automatic send_tick(input logic playing, input bit typed, input result_t want);
        int unsigned gap;
        result_t     predicted;
        gap = tx_gaps ? $urandom_range(0, 3) : 0;
        cfg_valid <= 1'b0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_playing <= playing;
        do @(posedge aclk); while (!s_ready);
        predicted = advance_sequencer(playing);
        step_words_due = {step_words_due, (typed ? want : predicted)};
    endtask

    // Write one register once every pending result has come back.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        s_valid <= 1'b0;
        while (step_words_due.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        store_reg(idx, data);
    endtask

    // Random length: mostly short, sometimes zero, the maximum or any 24-bit value.
    function automatic logic [23:0] pick_length(input int unsigned hi);
        case ($urandom_range(0, 9))
            0:       return 24'd0;
            1:       return 24'hFFFFFF;
            2:       return 24'($urandom);
            default: return 24'($urandom_range(1, hi));
        endcase
    endfunction

    // Random count: mostly in range, sometimes zero, the limit or beyond it.
    function automatic logic [5:0] pick_count(input int unsigned hi);
        case ($urandom_range(0, 9))
            0:       return 6'd0;
            1:       return 6'd63;
            2:       return 6'd32;
            3:       return 6'($urandom_range(33, 63));
            default: return 6'($urandom_range(1, hi));
        endcase
    endfunction

    function automatic row_t tick_row(input logic playing, input bit typed, input result_t want);
        row_t r;
        r.kind    = ROW_TICK;
        r.idx     = '0;
        r.data    = '0;
        r.playing = playing;
        r.typed   = typed;
        r.want    = want;
        return r;
    endfunction

    function automatic row_t write_row(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        row_t r;
        r.kind    = ROW_WRITE;
        r.idx     = idx;
        r.data    = data;
        r.playing = 1'b0;
        r.typed   = 1'b0;
        r.want    = '0;
        return r;
    endfunction

    // Result side: stall a random number of cycles before taking each word.
    initial begin
        int unsigned stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = rx_stalls ? $urandom_range(0, 3) : 0;
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Compare every accepted result word with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            words_seen++;
            if (step_words_due.size() == 0) begin
                flag_mismatch($sformatf("word %0d arrived with nothing expected", words_seen));
            end else begin
                head_word = step_words_due.pop_front();
                if (m_gate_open !== head_word.gate_open) begin
                    flag_mismatch($sformatf("word %0d gate_open got %b want %b",
                        words_seen, m_gate_open, head_word.gate_open));
                end
                if (m_step_index !== head_word.step_index) begin
                    flag_mismatch($sformatf("word %0d step_index got %0d want %0d",
                        words_seen, m_step_index, head_word.step_index));
                end
                if (m_step_start !== head_word.step_start) begin
                    flag_mismatch($sformatf("word %0d step_start got %b want %b",
                        words_seen, m_step_start, head_word.step_start));
                end
            end
        end
    end

    // Watchdog: end the run when no channel moves a word for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus: reset, directed table, random phases, then drain.
    initial begin
        row_t        plan[$];
        logic        play;
        bit          noisy;
        int unsigned span;

        reset_sequencer_copy();

        // Defaults right after reset: a stopped tick, the start of play, one more tick.
        plan = {plan, tick_row(1'b0, 1'b1, {1'b0, 5'd0, 1'b0})};
        plan = {plan, tick_row(1'b1, 1'b1, {1'b0, 5'd0, 1'b1})};
        plan = {plan, tick_row(1'b1, 1'b1, {1'b0, 5'd0, 1'b0})};

        // Zero moduli act as one; upper data bits must be masked off.
        plan = {plan, write_row(REG_BAR_LENGTH, 32'hFF00_0000)};
        plan = {plan, write_row(REG_RESYNC_BARS, 32'hFFFF_FFC0)};
        plan = {plan, write_row(REG_STEP_LENGTH, 32'h0000_0000)};
        plan = {plan, write_row(REG_GATE_LENGTH, 32'h0000_0000)};
        plan = {plan, write_row(REG_STEP_COUNT, 32'hFFFF_FFC0)};
        plan = {plan, write_row(REG_PATTERN_BITS, 32'hFFFF_FFFF)};
        plan = {plan, tick_row(1'b1, 1'b1, {1'b1, 5'd0, 1'b1})};
        plan = {plan, tick_row(1'b1, 1'b1, {1'b1, 5'd0, 1'b1})};
        plan = {plan, tick_row(1'b0, 1'b1, {1'b1, 5'd0, 1'b1})};

        // Largest bar, counts beyond their limits, a step every tick, short gate.
        plan = {plan, write_row(REG_BAR_LENGTH, 32'h00FF_FFFF)};
        plan = {plan, write_row(REG_RESYNC_BARS, 32'd63)};
        plan = {plan, write_row(REG_STEP_LENGTH, 32'd1)};
        plan = {plan, write_row(REG_GATE_LENGTH, 32'd2)};
        plan = {plan, write_row(REG_STEP_COUNT, 32'd63)};
        plan = {plan, write_row(REG_PATTERN_BITS, 32'h8000_0001)};
        repeat (6) plan = {plan, tick_row(1'b1, 1'b0, '0)};

        // Long steps let the step counter climb; an unmapped write changes nothing.
        plan = {plan, write_row(REG_STEP_LENGTH, 32'h00FF_FFFF)};
        plan = {plan, write_row(REG_UNMAPPED, 32'hFFFF_FFFF)};
        repeat (4) plan = {plan, tick_row(1'b1, 1'b0, '0)};

        // Shrunk step length and count: counters beyond them clear on the next tick.
        plan = {plan, write_row(REG_STEP_LENGTH, 32'd2)};
        plan = {plan, write_row(REG_STEP_COUNT, 32'd3)};
        plan = {plan, write_row(REG_GATE_LENGTH, 32'h00FF_FFFF)};
        repeat (4) plan = {plan, tick_row(1'b1, 1'b0, '0)};
        plan = {plan, tick_row(1'b0, 1'b0, '0)};
        plan = {plan, tick_row(1'b1, 1'b0, '0)};
        plan = {plan, tick_row(1'b0, 1'b0, '0)};

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                send_tick(plan[i].playing, plan[i].typed, plan[i].want);
            end
        end

        // Random phases: new values for a random choice of registers, then runs of play with rare stops,
        // or in some phases a noisy transport flag.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if ($urandom_range(0, 3) != 0) write_reg(REG_BAR_LENGTH, {8'($urandom), pick_length(48)});
            if ($urandom_range(0, 3) != 0) write_reg(REG_RESYNC_BARS, {26'($urandom), pick_count(4)});
            if ($urandom_range(0, 3) != 0) write_reg(REG_STEP_LENGTH, {8'($urandom), pick_length(12)});
            if ($urandom_range(0, 3) != 0) write_reg(REG_GATE_LENGTH, {8'($urandom), pick_length(30)});
            if ($urandom_range(0, 3) != 0) write_reg(REG_STEP_COUNT, {26'($urandom), pick_count(32)});
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 5))
                    0:       write_reg(REG_PATTERN_BITS, 32'h0000_0000);
                    1:       write_reg(REG_PATTERN_BITS, 32'hFFFF_FFFF);
                    default: write_reg(REG_PATTERN_BITS, $urandom);
                endcase
            end
            if ($urandom_range(0, 5) == 0) write_reg(REG_UNMAPPED, $urandom);

            tx_gaps   = ($urandom_range(0, 2) != 0);
            rx_stalls = ($urandom_range(0, 2) != 0);
            noisy     = ($urandom_range(0, 3) == 0);
            play      = 1'($urandom);
            span      = $urandom_range(95, 140);
            repeat (span) begin
                if (noisy) begin
                    play = 1'($urandom);
                end else if ($urandom_range(0, 19) == 0) begin
                    play = ~play;
                end
                send_tick(play, 1'b0, '0);
            end
        end

        // Drain, then give any stray word time to show up.
        s_valid   <= 1'b0;
        cfg_valid <= 1'b0;
        while (step_words_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[files.f]
design/bssg_pkg.sv
design/bssg_cfg_regs.sv
design/bssg_core.sv
design/bar_synced_step_gate_sequencer_top.sv
design/bssg_checker.sv
test/tb_top.sv
